@@ rtl/crc_remainder_generator_core_assert.svh @@
// assertion macros for the crc remainder generator
`ifndef CRC_REMAINDER_GENERATOR_CORE_ASSERT_SVH
`define CRC_REMAINDER_GENERATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define CRG_ASSERT(label, clock, resetn, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) else $error(msg);
`define CRG_ASSERT_NEXT(label, clock, resetn, cond, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) cond |=> prop) else $error(msg);
`else
`define CRG_ASSERT(label, clock, resetn, prop, msg)
`define CRG_ASSERT_NEXT(label, clock, resetn, cond, prop, msg)
`endif

`endif

@@ rtl/crg_pkg.sv @@
package crg_pkg;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned POLY_W     = 32;
    localparam int unsigned WIDTH_W    = 6;
    localparam int unsigned REM_W      = 32;

    localparam logic [POLY_W-1:0]  POLY_RESET  = 32'd5;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd3;

    typedef enum logic {
        REG_POLY  = 1'b0,
        REG_WIDTH = 1'b1
    } crg_reg_t;

    typedef struct packed {
        logic [POLY_W-1:0]  poly_low_bits;
        logic [WIDTH_W-1:0] crc_width;
    } crg_cfg_t;

endpackage

@@ rtl/crg_regs.sv @@
module crg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [crg_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [crg_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [crg_pkg::CFG_DATA_W-1:0]  prdata,
    output crg_pkg::crg_cfg_t               cfg
);
    import crg_pkg::*;

    logic [POLY_W-1:0]  poly_reg;
    logic [POLY_W-1:0]  poly_next;
    logic [WIDTH_W-1:0] width_reg;
    logic [WIDTH_W-1:0] width_next;
    logic               wr_en;
    crg_reg_t           sel;

    assign wr_en = psel & penable & pwrite;
    assign sel   = crg_reg_t'(paddr[2]);

    always_comb
    begin
        poly_next  = poly_reg;
        width_next = width_reg;
        if (wr_en)
        begin
            unique case (sel)
                REG_POLY:  poly_next  = pwdata[POLY_W-1:0];
                REG_WIDTH: width_next = pwdata[WIDTH_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg  <= POLY_RESET;
            width_reg <= WIDTH_RESET;
        end
        else
        begin
            poly_reg  <= poly_next;
            width_reg <= width_next;
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_POLY:  prdata = poly_reg;
            REG_WIDTH: prdata = CFG_DATA_W'(width_reg);
            default:   prdata = '0;
        endcase
    end

    assign cfg.poly_low_bits = poly_reg;
    assign cfg.crc_width     = width_reg;

endmodule

@@ rtl/crg_step.sv @@
module crg_step #(
    parameter int unsigned MAX_CRC_WIDTH = 32
) (
    input  crg_pkg::crg_cfg_t         cfg,
    input  logic [MAX_CRC_WIDTH-1:0]  rem_in,
    input  logic                      data_bit,
    output logic [MAX_CRC_WIDTH-1:0]  rem_out
);
    import crg_pkg::*;

    localparam int unsigned EW = 7;

    logic [EW-1:0]            width_ext;
    logic [EW-1:0]            width_eff;
    logic [EW-1:0]            top_idx;
    logic [MAX_CRC_WIDTH-1:0] mask;
    logic [MAX_CRC_WIDTH-1:0] rem_cut;
    logic [MAX_CRC_WIDTH-1:0] rem_shift;
    logic [MAX_CRC_WIDTH-1:0] poly_ext;
    logic                     top_bit;
    logic                     feedback;

    assign width_ext = EW'(cfg.crc_width);

    // clamp the width into 1..MAX_CRC_WIDTH
    always_comb
    begin
        priority if (width_ext == '0)
            width_eff = EW'(1);
        else if (width_ext > EW'(MAX_CRC_WIDTH))
            width_eff = EW'(MAX_CRC_WIDTH);
        else
            width_eff = width_ext;
    end

    assign top_idx = width_eff - EW'(1);

    always_comb
    begin
        mask    = '0;
        top_bit = 1'b0;
        for (int i = 0; i < MAX_CRC_WIDTH; i++)
        begin
            mask[i] = (EW'(i) < width_eff);
            top_bit = top_bit | (rem_in[i] & (EW'(i) == top_idx));
        end
    end

    assign rem_cut   = rem_in & mask;
    assign feedback  = top_bit ^ data_bit;
    assign rem_shift = (rem_cut << 1) & mask;
    assign poly_ext  = MAX_CRC_WIDTH'(cfg.poly_low_bits) & mask;
    assign rem_out   = feedback ? (rem_shift ^ poly_ext) : rem_shift;

endmodule

@@ rtl/crc_remainder_generator_core.sv @@
// bit-serial crc remainder generator with a programmable generator polynomial
//
// message bits enter on the bit channel (bit_valid, bit_stall, data_bit,
// last_bit), most significant bit first, one item per cycle while bit_stall is low.
// an item with last_bit set closes the message: in the cycle after it is taken its
// remainder shows on the rem channel (rem_valid, rem_stall, remainder), held in an
// output register, and the running remainder is cleared for the next message.
// throughput is one bit per cycle while bit_stall is low; the update loop through
// the remainder register sets that figure.
// while a result waits under rem_stall, bits that are not last are still
// taken; only a further last bit is held off by bit_stall.
// reset clears the running remainder and the output valid, and loads the
// polynomial register with 5 and the width register with 3.
// configuration goes over the apb port: polynomial at 0x0, width at 0x4; the user
// must write them only while no message is in progress, which the block does not enforce.
`include "crc_remainder_generator_core_assert.svh"

module crc_remainder_generator_core #(
    parameter int unsigned MAX_CRC_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            bit_valid,
    output logic                            bit_stall,
    input  logic                            data_bit,
    input  logic                            last_bit,
    output logic                            rem_valid,
    input  logic                            rem_stall,
    output logic [crg_pkg::REM_W-1:0]       remainder,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [crg_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [crg_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [crg_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import crg_pkg::*;

    crg_cfg_t                 cfg;
    logic [MAX_CRC_WIDTH-1:0] run_reg;
    logic [MAX_CRC_WIDTH-1:0] run_next;
    logic [MAX_CRC_WIDTH-1:0] step_out;
    logic [REM_W-1:0]         rem_reg;
    logic [REM_W-1:0]         rem_next;
    logic                     rem_valid_reg;
    logic                     rem_valid_next;
    logic                     bit_acc;
    logic                     rem_acc;

    crg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    crg_step #(
        .MAX_CRC_WIDTH (MAX_CRC_WIDTH)
    ) u_step (
        .cfg      (cfg),
        .rem_in   (run_reg),
        .data_bit (data_bit),
        .rem_out  (step_out)
    );

    assign pready    = 1'b1;
    assign bit_stall = rem_valid_reg & rem_stall & last_bit;
    assign bit_acc   = bit_valid & ~bit_stall;
    assign rem_acc   = rem_valid_reg & ~rem_stall;

    always_comb
    begin
        run_next       = run_reg;
        rem_next       = rem_reg;
        rem_valid_next = rem_valid_reg;
        if (rem_acc)
            rem_valid_next = 1'b0;
        if (bit_acc)
        begin
            if (last_bit)
            begin
                run_next       = '0;
                rem_next       = REM_W'(step_out);
                rem_valid_next = 1'b1;
            end
            else
                run_next = step_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= '0;
            rem_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            rem_valid_reg <= rem_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    assign rem_valid = rem_valid_reg;
    assign remainder = rem_reg;

    `CRG_ASSERT_NEXT(a_clear_after_last, clk, rst_n, bit_acc && last_bit, run_reg == '0, "running remainder not cleared after last item")
    `CRG_ASSERT_NEXT(a_result_from_last, clk, rst_n, bit_acc && last_bit, rem_valid_reg, "no result after last item")
    `CRG_ASSERT_NEXT(a_result_drains, clk, rst_n, rem_acc && !(bit_acc && last_bit), !rem_valid_reg, "result repeated after being taken")
    `CRG_ASSERT(a_stall_only_when_full, clk, rst_n, bit_stall |-> rem_valid_reg && last_bit, "input stalled without a pending result")

endmodule

@@ tb/crc_remainder_generator_core_tb.sv @@
module crc_remainder_generator_core_tb;

    import crg_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 3000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_ITEMS = 1450;

    typedef struct {
        logic data;
        logic last;
    } msg_bit_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  bit_valid = 1'b0;
    logic                  bit_stall;
    logic                  data_bit = 1'b0;
    logic                  last_bit = 1'b0;
    logic                  rem_valid;
    logic                  rem_stall = 1'b0;
    logic [REM_W-1:0]      remainder;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    msg_bit_t          bit_queue[$];
    msg_bit_t          next_bit;
    logic [REM_W-1:0]  expected_remainders[$];
    logic [POLY_W-1:0] poly_cfg = POLY_RESET;
    logic [WIDTH_W-1:0] width_cfg = WIDTH_RESET;
    logic [REM_W-1:0]  crc_state = '0;
    logic [REM_W-1:0]  crc_next;
    logic [REM_W-1:0]  want;

    int unsigned queued_bits = 0;
    int unsigned accepted_bits = 0;
    int unsigned random_bits = 0;
    int unsigned error_count = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    int unsigned idle_cycles = 0;

    crc_remainder_generator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bit_valid (bit_valid),
        .bit_stall (bit_stall),
        .data_bit  (data_bit),
        .last_bit  (last_bit),
        .rem_valid (rem_valid),
        .rem_stall (rem_stall),
        .remainder (remainder),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    function automatic logic [REM_W-1:0] next_remainder(input logic [REM_W-1:0] cur,
                                                        input logic din);
        int unsigned w;
        logic [REM_W-1:0] m;
        logic [REM_W-1:0] r;
        logic fb;
        w = (width_cfg == 0) ? 1 : ((width_cfg > 32) ? 32 : width_cfg);
        m = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
        r = cur & m;
        fb = r[w-1] ^ din;
        r = (r << 1) & m;
        if (fb)
        begin
            r = r ^ (poly_cfg & m);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [REM_W-1:0] got,
                                   input logic [REM_W-1:0] exp_val);
        $display("error at %0t: %s got %h want %h", $realtime, what, got, exp_val);
        error_count++;
    endtask

    task automatic write_reg(input crg_reg_t sel, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_POLY:  poly_cfg = val;
            REG_WIDTH: width_cfg = val[WIDTH_W-1:0];
            default:   ;
        endcase
    endtask

    task automatic configure(input logic [POLY_W-1:0] poly, input logic [CFG_DATA_W-1:0] w);
        write_reg(REG_POLY, poly);
        write_reg(REG_WIDTH, w);
    endtask

    task automatic queue_message(input logic [127:0] bits, input int unsigned len);
        msg_bit_t b;
        for (int i = len - 1; i >= 0; i--)
        begin
            b.data = bits[i];
            b.last = (i == 0);
            bit_queue.push_back(b);
            queued_bits++;
        end
    endtask

    task automatic queue_random_message(input int unsigned len);
        msg_bit_t b;
        for (int i = len - 1; i >= 0; i--)
        begin
            b.data = 1'($urandom_range(0, 1));
            b.last = (i == 0);
            bit_queue.push_back(b);
            queued_bits++;
            random_bits++;
        end
    endtask

    task automatic drain;
        while (bit_queue.size() != 0 || accepted_bits != queued_bits
               || expected_remainders.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // item sender: bursts with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            bit_valid <= 1'b0;
        end
        else if (!bit_valid || !bit_stall)
        begin
            if (gap_left != 0)
            begin
                gap_left  <= gap_left - 1;
                bit_valid <= 1'b0;
            end
            else if (bit_queue.size() != 0)
            begin
                next_bit = bit_queue.pop_front();
                bit_valid <= 1'b1;
                data_bit  <= next_bit.data;
                last_bit  <= next_bit.last;
                if (burst_left <= 1)
                begin
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                              : $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                bit_valid <= 1'b0;
            end
        end
    end

    // result receiver: stall pattern plus occasional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rem_stall <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            rem_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            rem_stall   <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(10, 150);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0:       rem_stall <= 1'b0;
                1:       rem_stall <= ($urandom_range(0, 3) == 0);
                default: rem_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // prediction on accepted bits, checking on accepted remainders
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (bit_valid && !bit_stall)
            begin
                accepted_bits++;
                crc_next = next_remainder(crc_state, data_bit);
                if (last_bit)
                begin
                    expected_remainders.push_back(crc_next);
                    crc_state = '0;
                end
                else
                begin
                    crc_state = crc_next;
                end
            end
            if (rem_valid && !rem_stall)
            begin
                if (expected_remainders.size() == 0)
                begin
                    report_mismatch("unexpected remainder", remainder, '0);
                end
                else
                begin
                    want = expected_remainders.pop_front();
                    if (remainder !== want)
                    begin
                        report_mismatch("remainder", remainder, want);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((bit_valid && !bit_stall) || (rem_valid && !rem_stall) || psel)
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        logic [POLY_W-1:0] poly;
        logic [CFG_DATA_W-1:0] w;
        int unsigned msgs;
        int unsigned pick;
        int unsigned phase_no;
        phase_no = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: poly 5, width 3
        queue_message(128'b1, 1);
        queue_message(128'b0, 1);
        queue_message(128'b1011, 4);
        drain();
        // widest remainder, all-ones polynomial
        configure(32'hFFFF_FFFF, 32);
        queue_message(128'hFF, 8);
        drain();
        // narrowest width, zero polynomial
        configure(32'h0, 1);
        queue_message(128'b11, 2);
        drain();
        // width zero behaves as one
        configure(32'h1, 0);
        queue_message(128'b101, 3);
        drain();
        // width above the maximum behaves as the maximum
        configure(32'h04C1_1DB7, 63);
        queue_message(128'b10110, 5);
        drain();

        while (random_bits < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       w = 1;
                1:       w = 32;
                2:       w = 0;
                3:       w = $urandom_range(33, 63);
                default: w = $urandom_range(1, 32);
            endcase
            pick = $urandom_range(0, 9);
            poly = (pick == 0) ? 32'h0 : ((pick == 1) ? 32'hFFFF_FFFF : $urandom);
            configure(poly, w);
            if (phase_no == 0 || $urandom_range(0, 7) == 0)
            begin
                hold_requests++;
            end
            msgs = $urandom_range(3, 10);
            for (int m = 0; m < msgs; m++)
            begin
                queue_random_message(($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
                                                                 : $urandom_range(1, 24));
            end
            drain();
            phase_no++;
        end

        repeat (10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
